@@ design/spsc_pkg.sv @@
// Package for smo_pair_step_clip: input/output word structs, case codes
// and widths shared by the divider cell and the top level. No dependencies.
package spsc_pkg;

	localparam int NUM_W = 66;  // g1 - g2 +/- 2.0 fits in 66 signed bits
	localparam int DEN_W = 27;  // k11 + k22 - 2*k12, signed

	localparam logic [2:0] CASE_PP   = 3'd0;
	localparam logic [2:0] CASE_PM   = 3'd1;
	localparam logic [2:0] CASE_MP   = 3'd2;
	localparam logic [2:0] CASE_MM   = 3'd3;
	localparam logic [2:0] CASE_FREE = 3'd4;

	typedef struct packed {
		logic signed [63:0] alpha_first;
		logic signed [63:0] alpha_second;
		logic               label_first_neg;
		logic               label_second_neg;
		logic        [62:0] cap_first;
		logic        [62:0] cap_second;
		logic signed [63:0] grad_sum_first;
		logic signed [63:0] grad_sum_second;
		logic        [24:0] kern_first_first;
		logic        [24:0] kern_first_second;
		logic        [24:0] kern_second_second;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] new_alpha_first;
		logic signed [63:0] new_alpha_second;
		logic signed [63:0] step_taken;
		logic               moved;
		logic        [2:0]  case_code;
		logic               degenerate;
	} out_word_t;

	// context carried alongside the divider
	typedef struct packed {
		logic               vld;
		logic               degen;
		logic               neg;
		logic signed [63:0] a1;
		logic signed [63:0] a2;
		logic               n1;
		logic               n2;
		logic        [62:0] c1;
		logic        [62:0] c2;
	} ctx_t;

	function automatic logic signed [63:0] sat64(input logic signed [129:0] v);
		logic signed [129:0] mx;
		logic signed [129:0] mn;
		begin
			mx = 130'sh7FFFFFFFFFFFFFFF;
			mn = -mx - 130'sd1;
			if (v > mx) sat64 = mx[63:0];
			else if (v < mn) sat64 = mn[63:0];
			else sat64 = v[63:0];
		end
	endfunction

endpackage

@@ design/smo_pair_step_clip.sv @@
// Top level of smo_pair_step_clip: input register, divider cell chain, clip stage.
// Depends on spsc_pkg, spsc_div_cell, spsc_clip.
//
// Takes one word per cycle while the pipe is not stalled and returns one result word per input word, in order.
// The pipe is one input stage, 32 restoring-divider cells of four
// quotient bits each (128-bit quotient), and three clip stages (box test,
// midpoint and saturation, new multipliers into the output register).
// The whole pipe advances together; it stalls only while the output word is
// held and not taken.
module smo_pair_step_clip import spsc_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int QW    = 128;
	localparam int BPC   = 4;
	localparam int CELLS = QW / BPC;

	logic en;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	// input stage: numerator, denominator, sign
	logic signed [NUM_W-1:0] num;
	logic signed [DEN_W-1:0] den;
	logic        [NUM_W-1:0] num_mag;
	logic signed [NUM_W-1:0] two;
	ctx_t                    ctx_n;
	ctx_t                    ctx_d_s1;
	logic                    vld_s1;
	ctx_t                    ctx_s1;
	logic [QW-1:0]           dvd_s1;
	logic [DEN_W-1:0]        den_s1;

	always_comb begin
		two = NUM_W'(2) <<< FRAC_BITS;
		num = NUM_W'(in_data.grad_sum_first) - NUM_W'(in_data.grad_sum_second);
		if (in_data.label_first_neg && !in_data.label_second_neg) num = num + two;
		if (!in_data.label_first_neg && in_data.label_second_neg) num = num - two;
		den = $signed({2'b00, in_data.kern_first_first})
			+ $signed({2'b00, in_data.kern_second_second})
			- $signed({1'b0, in_data.kern_first_second, 1'b0});
		num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		ctx_n.vld   = in_valid;
		ctx_n.degen = (den <= 0);
		ctx_n.neg   = num[NUM_W-1];
		ctx_n.a1    = in_data.alpha_first;
		ctx_n.a2    = in_data.alpha_second;
		ctx_n.n1    = in_data.label_first_neg;
		ctx_n.n2    = in_data.label_second_neg;
		ctx_n.c1    = in_data.cap_first;
		ctx_n.c2    = in_data.cap_second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_d_s1 <= ctx_n;
			dvd_s1   <= QW'({{(QW-NUM_W){1'b0}}, num_mag} << FRAC_BITS);
			den_s1   <= (den <= 0) ? DEN_W'(1) : den;
		end
	end

	always_comb begin
		ctx_s1     = ctx_d_s1;
		ctx_s1.vld = vld_s1;
	end

	ctx_t             ctx_c [CELLS+1];
	logic [QW-1:0]    dvd_c [CELLS+1];
	logic [DEN_W-1:0] rem_c [CELLS+1];
	logic [DEN_W-1:0] den_c [CELLS+1];

	assign ctx_c[0] = ctx_s1;
	assign dvd_c[0] = dvd_s1;
	assign rem_c[0] = '0;
	assign den_c[0] = den_s1;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		spsc_div_cell #(.QW(QW), .BPC(BPC)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctx_in  (ctx_c[i]),
			.dvd_in  (dvd_c[i]),
			.rem_in  (rem_c[i]),
			.den_in  (den_c[i]),
			.ctx_out (ctx_c[i+1]),
			.dvd_out (dvd_c[i+1]),
			.rem_out (rem_c[i+1]),
			.den_out (den_c[i+1])
		);
	end

	spsc_clip u_clip (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctx     (ctx_c[CELLS]),
		.quo_mag (dvd_c[CELLS]),
		.vld_q   (out_valid),
		.res_q   (out_data)
	);

endmodule

@@ design/spsc_div_cell.sv @@
// One restoring-division cell of the divider chain: BPC quotient bits per stage.
// Depends on spsc_pkg.
module spsc_div_cell import spsc_pkg::*; #(
	parameter int QW  = 128,
	parameter int BPC = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctx_t               ctx_in,
	input  logic [QW-1:0]      dvd_in,
	input  logic [DEN_W-1:0]   rem_in,
	input  logic [DEN_W-1:0]   den_in,
	output ctx_t               ctx_out,
	output logic [QW-1:0]      dvd_out,
	output logic [DEN_W-1:0]   rem_out,
	output logic [DEN_W-1:0]   den_out
);

	logic [DEN_W-1:0] rem_n;
	logic [QW-1:0]    dvd_n;
	logic [DEN_W:0]   trial;
	logic             vld_q;
	ctx_t             ctx_q;

	// dividend shifts left; quotient bits shift into the low end
	always_comb begin
		rem_n = rem_in;
		dvd_n = dvd_in;
		trial = '0;
		for (int b = 0; b < BPC; b++) begin
			trial = {rem_n, dvd_n[QW-1]};
			dvd_n = {dvd_n[QW-2:0], 1'b0};
			if (trial >= {1'b0, den_in}) begin
				trial = trial - {1'b0, den_in};
				dvd_n[0] = 1'b1;
			end
			rem_n = trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= ctx_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q   <= ctx_in;
			dvd_out <= dvd_n;
			rem_out <= rem_n;
			den_out <= den_in;
		end
	end

	always_comb begin
		ctx_out     = ctx_q;
		ctx_out.vld = vld_q;
	end

endmodule

@@ design/spsc_clip.sv @@
// Box test and midpoint clipping, with saturation and output register.
// Three stages: box test, final step, new multipliers. Depends on spsc_pkg.
module spsc_clip import spsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  ctx_t        ctx,
	input  logic [127:0] quo_mag,
	output logic        vld_q,
	output out_word_t   res_q
);

	logic signed [129:0] mag, a1, a2, c1, c2, nu, t1, t2;
	logic signed [129:0] lo1, hi1, lo2, hi2, lo, hi;
	logic                clipped;
	logic                vld_s1, vld_s2;
	ctx_t                ctx_s1, ctx_s2;
	logic signed [129:0] nu_s1, lo_s1, hi_s1;
	logic                clip_s1, clip_s2;
	logic signed [129:0] fin;
	logic signed [63:0]  step, step_s2;
	logic signed [129:0] b1, b2, sw;
	out_word_t           res;

	// stage 1: box test and feasible interval
	always_comb begin
		mag = $signed({2'b00, quo_mag});
		nu  = ctx.neg ? -mag : mag;
		a1  = 130'(ctx.a1);
		a2  = 130'(ctx.a2);
		c1  = $signed({67'd0, ctx.c1});
		c2  = $signed({67'd0, ctx.c2});
		// sign of the step folded into the add/subtract choice
		t1  = (ctx.n1 ^ ctx.neg) ? a1 - mag : a1 + mag;
		t2  = (ctx.n2 ^ ctx.neg) ? a2 + mag : a2 - mag;
		clipped = (t1 < 0) || (t1 > c1) || (t2 < 0) || (t2 > c2);
		lo1 = ctx.n1 ? a1 - c1 : -a1;
		hi1 = ctx.n1 ? a1 : c1 - a1;
		lo2 = ctx.n2 ? -a2 : a2 - c2;
		hi2 = ctx.n2 ? c2 - a2 : a2;
		lo  = (lo1 < lo2) ? lo2 : lo1;
		hi  = (hi1 < hi2) ? hi1 : hi2;
	end

	// stage 2: final step, midpoint rounds toward minus infinity
	always_comb begin
		if (!clip_s1) fin = nu_s1;
		else if (hi_s1 < lo_s1) fin = '0;
		else fin = (lo_s1 + hi_s1) >>> 1;
		step = sat64(fin);
	end

	// stage 3: new multipliers from the saturated step
	always_comb begin
		b1 = 130'(ctx_s2.a1);
		b2 = 130'(ctx_s2.a2);
		sw = 130'(step_s2);
		res.step_taken       = step_s2;
		res.new_alpha_first  = sat64(ctx_s2.n1 ? b1 - sw : b1 + sw);
		res.new_alpha_second = sat64(ctx_s2.n2 ? b2 + sw : b2 - sw);
		if (!clip_s2) res.case_code = CASE_FREE;
		else if (ctx_s2.n1) res.case_code = ctx_s2.n2 ? CASE_MM : CASE_MP;
		else res.case_code = ctx_s2.n2 ? CASE_PM : CASE_PP;
		res.degenerate       = 1'b0;
		if (ctx_s2.degen) begin
			res.step_taken       = '0;
			res.new_alpha_first  = ctx_s2.a1;
			res.new_alpha_second = ctx_s2.a2;
			res.case_code        = CASE_FREE;
			res.degenerate       = 1'b1;
		end
		res.moved = (res.step_taken != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= ctx.vld;
			vld_s2 <= vld_s1;
			vld_q  <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1  <= ctx;
			nu_s1   <= nu;
			lo_s1   <= lo;
			hi_s1   <= hi;
			clip_s1 <= clipped;
			ctx_s2  <= ctx_s1;
			clip_s2 <= clip_s1;
			step_s2 <= step;
			res_q   <= res;
		end
	end

endmodule

@@ bench/smo_pair_step_clip_chk.sv @@
// Checker for smo_pair_step_clip: watches both channels, predicts each result word
// from the accepted input word and compares the whole word. Depends on spsc_pkg.
module smo_pair_step_clip_chk import spsc_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	output int        fail_count,
	output int        pending
);

	typedef logic signed [159:0] wide_t;

	out_word_t step_queue[$];

	function automatic logic signed [63:0] clamp64(input wide_t v);
		if (v > wide_t'(64'sh7FFFFFFFFFFFFFFF)) begin
			return 64'sh7FFFFFFFFFFFFFFF;
		end
		if (v < -wide_t'(64'sh7FFFFFFFFFFFFFFF) - 1) begin
			return 64'sh8000000000000000;
		end
		return v[63:0];
	endfunction

	function automatic out_word_t pair_step(input in_word_t w);
		wide_t a1, a2, c1, c2, num, nu, t1, t2;
		wide_t lo1, hi1, lo2, hi2, lo, hi, fin, sw;
		logic signed [27:0] den;
		logic signed [63:0] step;
		logic n1, n2;
		out_word_t r;
		a1 = wide_t'(w.alpha_first);
		a2 = wide_t'(w.alpha_second);
		c1 = {97'b0, w.cap_first};
		c2 = {97'b0, w.cap_second};
		n1 = w.label_first_neg;
		n2 = w.label_second_neg;
		den = $signed({3'b0, w.kern_first_first}) + $signed({3'b0, w.kern_second_second})
			- $signed({2'b0, w.kern_first_second, 1'b0});
		r.new_alpha_first = w.alpha_first;
		r.new_alpha_second = w.alpha_second;
		r.step_taken = '0;
		r.case_code = CASE_FREE;
		r.degenerate = 1'b0;
		if (den <= 0) begin
			r.degenerate = 1'b1;
		end else begin
			num = wide_t'($signed(w.grad_sum_first)) - wide_t'($signed(w.grad_sum_second));
			if (n1 && !n2) num = num + (wide_t'(2) <<< FRAC_BITS);
			if (!n1 && n2) num = num - (wide_t'(2) <<< FRAC_BITS);
			// signed division truncates toward zero
			nu = (num <<< FRAC_BITS) / wide_t'(den);
			t1 = n1 ? a1 - nu : a1 + nu;
			t2 = n2 ? a2 + nu : a2 - nu;
			if (t1 < 0 || t1 > c1 || t2 < 0 || t2 > c2) begin
				lo1 = n1 ? a1 - c1 : -a1;
				hi1 = n1 ? a1 : c1 - a1;
				lo2 = n2 ? -a2 : a2 - c2;
				hi2 = n2 ? c2 - a2 : a2;
				lo = (lo1 > lo2) ? lo1 : lo2;
				hi = (hi1 < hi2) ? hi1 : hi2;
				r.case_code = n1 ? (n2 ? CASE_MM : CASE_MP) : (n2 ? CASE_PM : CASE_PP);
				fin = (hi < lo) ? wide_t'(0) : ((lo + hi) >>> 1);
			end else begin
				fin = nu;
			end
			step = clamp64(fin);
			sw = wide_t'(step);
			r.step_taken = step;
			r.new_alpha_first = clamp64(n1 ? a1 - sw : a1 + sw);
			r.new_alpha_second = clamp64(n2 ? a2 + sw : a2 - sw);
		end
		r.moved = (r.step_taken != 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) step_queue.push_back(pair_step(in_data));
			if (out_valid && out_ready) begin
				if (step_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected result word %h", out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = step_queue.pop_front();
					if (want !== out_data) begin
						if (fail_count < 10) begin
							$display("mismatch: alpha1 %h/%h alpha2 %h/%h step %h/%h",
								want.new_alpha_first, out_data.new_alpha_first,
								want.new_alpha_second, out_data.new_alpha_second,
								want.step_taken, out_data.step_taken);
							$display("  moved %b/%b case %0d/%0d degen %b/%b",
								want.moved, out_data.moved, want.case_code,
								out_data.case_code, want.degenerate, out_data.degenerate);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= step_queue.size();
		end
	end

endmodule

@@ bench/smo_pair_step_clip_tb.sv @@
// Testbench top for smo_pair_step_clip: clock, reset, directed and random pair
// steps with idling and back-pressure. Depends on spsc_pkg, smo_pair_step_clip_chk.
module smo_pair_step_clip_tb import spsc_pkg::*; ();

	localparam int FRAC = 24;
	localparam logic [24:0] KONE = 25'd16777216;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	int        fail_count;
	int        pending;
	int        phase;
	int        sent;

	smo_pair_step_clip #(.FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	smo_pair_step_clip_chk #(.FRAC_BITS(FRAC)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] scaled64();
		return rand64() >> $urandom_range(0, 63);
	endfunction

	function automatic logic [24:0] rand_kern();
		if ($urandom_range(0, 19) == 0) return KONE;
		return 25'($urandom_range(0, 16777216));
	endfunction

	// receiver: random stalls by phase, plus one long hold-off to fill the pipe
	always @(negedge clk) begin
		int hold;
		if (!arst_n) begin
			hold = 0;
			out_ready <= 1'b0;
		end else begin
			if (sent == 300 && hold == 0) hold = 400;
			if (hold > 1) begin
				hold = hold - 1;
				out_ready <= 1'b0;
			end else if (phase == 0) begin
				out_ready <= ($urandom_range(0, 99) >= 86);
			end else if (phase == 1) begin
				out_ready <= ($urandom_range(0, 99) >= 10);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send(input in_word_t w);
		while ((phase == 0 && $urandom_range(0, 99) < 10) ||
			(phase == 1 && $urandom_range(0, 99) < 86)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sent = sent + 1;
		@(negedge clk);
	endtask

	task automatic send_pair(input logic [63:0] a1, input logic [63:0] a2,
		input logic n1, input logic n2, input logic [62:0] c1, input logic [62:0] c2,
		input logic [63:0] g1, input logic [63:0] g2,
		input logic [24:0] k11, input logic [24:0] k12, input logic [24:0] k22);
		in_word_t w;
		w.alpha_first = a1;
		w.alpha_second = a2;
		w.label_first_neg = n1;
		w.label_second_neg = n2;
		w.cap_first = c1;
		w.cap_second = c2;
		w.grad_sum_first = g1;
		w.grad_sum_second = g2;
		w.kern_first_first = k11;
		w.kern_first_second = k12;
		w.kern_second_second = k22;
		send(w);
	endtask

	task automatic send_random();
		logic [62:0] c1, c2;
		logic [63:0] sc;
		if ($urandom_range(0, 9) < 2) begin
			// noise over the full field ranges, kernel entries up to one
			send_pair(rand64(), rand64(), 1'($urandom), 1'($urandom),
				63'(rand64()), 63'(rand64()),
				rand64(), rand64(), rand_kern(), rand_kern(), rand_kern());
		end else begin
			// well-formed: multipliers inside their boxes, modest gradients
			sc = 64'd1 << $urandom_range(20, 40);
			c1 = 63'(scaled64() % sc);
			c2 = 63'(scaled64() % sc);
			send_pair(c1 == 0 ? 64'd0 : {1'b0, c1} - 64'(63'(rand64()) % c1),
				c2 == 0 ? 64'd0 : 64'(63'(rand64()) % c2),
				1'($urandom), 1'($urandom), c1, c2,
				$signed(scaled64() % sc) - $signed(sc >> 1),
				$signed(scaled64() % sc) - $signed(sc >> 1),
				rand_kern(), 25'($urandom_range(0, 8388608)), rand_kern());
		end
	endtask

	initial begin
		#(20 * 400000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [63:0] one;
		one = 64'd1 << FRAC;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		phase = 0;
		sent = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every label pair, unclipped
		for (int i = 0; i < 4; i++) begin
			send_pair(one, one, i[1], i[0], 63'(4 * one), 63'(4 * one), 64'd0, 64'd0,
				KONE, 25'd0, KONE);
		end
		// every label pair, clipped with big gradient difference
		for (int i = 0; i < 4; i++) begin
			send_pair(one, 2 * one, i[1], i[0], 63'(3 * one), 63'(5 * one), 100 * one,
				-100 * one, KONE, 25'd1, KONE);
		end
		// degenerate denominators: zero and negative
		send_pair(one, one, 1'b0, 1'b1, 63'(one), 63'(one), one, 64'd0, KONE, KONE, KONE);
		send_pair(64'h8000000000000000, 64'h7FFFFFFFFFFFFFFF, 1'b1, 1'b0, '1, '1,
			64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000, 25'd0, KONE, 25'd0);
		// denominator of one with extreme gradients: clipped step
		send_pair(64'd0, 64'd0, 1'b0, 1'b0, '1, '1, 64'h7FFFFFFFFFFFFFFF,
			64'h8000000000000000, 25'd1, 25'd0, 25'd0);
		send_pair(64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000, 1'b1, 1'b1, '1, '1,
			64'h8000000000000000, 64'h7FFFFFFFFFFFFFFF, 25'd0, 25'd0, 25'd1);
		// multipliers outside boxes, the first with an empty feasible interval
		send_pair(-one, 10 * one, 1'b0, 1'b0, 63'(one), 63'(one), one, 64'd0,
			KONE, 25'd0, 25'd0);
		send_pair(64'h8000000000000000, 64'h8000000000000000, 1'b0, 1'b1, '0, '0,
			one, -one, KONE, 25'd0, KONE);
		// zero caps, zero multipliers
		send_pair(64'd0, 64'd0, 1'b1, 1'b0, '0, '0, 64'd0, 64'd0, KONE, 25'd0, KONE);
		// odd sum of bounds, midpoint rounding down, then an empty feasible interval
		send_pair(64'd1, 64'd2, 1'b0, 1'b0, 63'd3, 63'd4, 64'd1 << 40, 64'd0,
			25'd1, 25'd0, 25'd0);
		send_pair(-64'sd3, 64'd0, 1'b1, 1'b1, 63'd4, 63'd6, 64'd0, 64'd1 << 40,
			25'd1, 25'd0, 25'd0);

		for (int n = 0; n < 1400; n++) begin
			if (n == 500) phase = 1;
			if (n == 950) phase = 2;
			send_random();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ smo_pair_step_clip.f @@
design/spsc_pkg.sv
design/spsc_div_cell.sv
design/spsc_clip.sv
design/smo_pair_step_clip.sv
bench/smo_pair_step_clip_chk.sv
bench/smo_pair_step_clip_tb.sv
